FILE: hw/rtl/mslc_pkg.sv
// mslc_pkg: shared constants, types and helpers for the mip slice layout calculator
// no dependencies; used by mip_slice_layout_calculator

package mslc_pkg;

	localparam int MAX_LEVELS   = 15;
	localparam int LVL_W        = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_W       = $clog2(PAGE_BYTES);
	localparam int CACHE_BANKS  = 8;
	localparam int UB_ROW_BYTES = 1024;
	localparam int PG_UB_ROWS   = PAGE_BYTES / UB_ROW_BYTES;
	localparam int PG_1_5       = (PG_UB_ROWS * 3) >> 1;
	localparam int PC_UB_ROWS   = (PAGE_BYTES * CACHE_BANKS) / UB_ROW_BYTES;
	localparam int PC_MINUS_1_5 = PC_UB_ROWS - PG_1_5;
	localparam int PC_W         = $clog2(PC_UB_ROWS);
	localparam int RASTER_BYTES = 64;
	localparam int ROW_ALIGN    = 64;
	localparam int DIV_K        = 24;
	localparam int DIVD_W       = 17;
	localparam int DIVS_W       = 7;
	localparam int RECIP_W      = DIV_K + 1;
	localparam int DIV_DEPTH    = 1 << DIVS_W;

	typedef enum logic [2:0] {
		MODE_RASTER    = 3'd0,
		MODE_LT        = 3'd1,
		MODE_UBL1      = 3'd2,
		MODE_UBL2      = 3'd3,
		MODE_UIF_NOXOR = 3'd4,
		MODE_UIF_XOR   = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DW,
		S_DH,
		S_RW,
		S_RH,
		S_PAD,
		S_SL,
		S_WH,
		S_ACC,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_ERD,
		S_ELD
	} state_t;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] stride;
		logic [16:0] rows;
		logic [31:0] size;
		mode_t       mode;
		logic [4:0]  pad;
		logic [15:0] ublk;
	} entry_t;

	// smallest power of two not below x, x of zero or one gives one
	function automatic logic [14:0] pow2_up(input logic [13:0] x);
		logic [13:0] y;
		logic [14:0] r;
		y = x - 14'd1;
		r = 15'd1;
		if (x > 14'd1) begin
			for (int i = 0; i < 14; i++) begin
				if (y[i]) begin
					r = 15'd1 << (i + 1);
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/mip_slice_layout_calculator.sv
// mip_slice_layout_calculator: lays out all mip levels of one texture per input beat
// depends on mslc_pkg; holds the level table memory and a reciprocal-based divider

// One input beat describes a texture; the block answers with one output beat per mip
// level, level 0 first, the last beat flagged and carrying the image size and layer
// stride. Levels are worked smallest first through one shared divider (a reciprocal
// multiply with a registered product) that runs four divisions per level; results go
// to a level table memory and are read back one at a time, each beat waiting on the
// output stall. The input is stalled until the last beat of an item is loaded, so a
// new texture is taken only once the previous one is through.

module mip_slice_layout_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] base_width,
	input  logic [14:0] base_height,
	input  logic [11:0] base_depth,
	input  logic [4:0]  bytes_per_block,
	input  logic [3:0]  utile_width,
	input  logic [3:0]  utile_height,
	input  logic [3:0]  block_width,
	input  logic [3:0]  block_height,
	input  logic [3:0]  level_count,
	input  logic [11:0] layer_count,
	input  logic        multisampled,
	input  logic [1:0]  image_kind,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  level_index,
	output logic [2:0]  tiling_mode,
	output logic [31:0] slice_offset,
	output logic [31:0] row_stride,
	output logic [16:0] padded_rows,
	output logic [4:0]  uif_pad,
	output logic [15:0] rows_in_uif_blocks,
	output logic [31:0] slice_bytes,
	output logic [31:0] total_bytes,
	output logic [31:0] layer_stride,
	output logic        overflow,
	output logic        last
);

	localparam int LW = mslc_pkg::LVL_W;
	localparam int DW = mslc_pkg::DIVD_W;
	localparam int SW = mslc_pkg::DIVS_W;
	localparam int PW = mslc_pkg::PAGE_W;

	mslc_pkg::state_t state_q, state_d;

	// captured texture description
	logic [14:0] w_q, h_q;
	logic [11:0] d_q;
	logic [4:0]  cpp_q;
	logic [3:0]  utw_q, uth_q, bw_q, bh_q;
	logic [11:0] layers_q;
	logic        msaa_q, tiled_q, is3d_q;
	logic [15:0] pw_q, ph_q;
	logic [12:0] pd_q;
	logic [LW-1:0] last_q, lv_q, emit_q;

	// level work registers
	logic [DW-1:0] lw_q, lh_q;
	logic [SW-1:0] ah_q;
	mslc_pkg::mode_t mode_q;
	logic [4:0]  pad_q;
	logic [15:0] hub_q;
	logic [21:0] stride_q;
	logic [31:0] slice_q, whole_q, run_q;
	logic        page_q;
	logic [31:0] off0_q, size0_q, total_q, lstride_q, lprod_q;
	logic [PW-1:0] shift_q;
	logic        ov_q;

	// divider
	logic [DW-1:0] dx;
	logic [SW-1:0] da;
	logic [mslc_pkg::RECIP_W-1:0] recip [mslc_pkg::DIV_DEPTH];
	logic [DW+mslc_pkg::RECIP_W-1:0] prod_s1;
	logic [SW-1:0] da_s1;
	logic [DW-1:0] q, qa;
	logic [DW+SW-1:0] qa_full;

	logic [SW-1:0] rast_align [32];

	// level table
	mslc_pkg::entry_t mem [mslc_pkg::MAX_LEVELS];
	mslc_pkg::entry_t wr_entry, rd_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  idx_q;
	logic [2:0]  mode_o_q;
	logic [31:0] off_o_q, stride_o_q, size_o_q, total_o_q, lstride_o_q;
	logic [16:0] rows_o_q;
	logic [4:0]  pad_o_q;
	logic [15:0] ublk_o_q;
	logic        ov_o_q, last_o_q;

	for (genvar Dv = 1; Dv < mslc_pkg::DIV_DEPTH; Dv++) begin : g_recip
		assign recip[Dv] = mslc_pkg::RECIP_W'(((64'd1 << mslc_pkg::DIV_K) + Dv - 1) / Dv);
	end
	assign recip[0] = '0;

	for (genvar Cv = 1; Cv < 32; Cv++) begin : g_rast
		assign rast_align[Cv] = SW'(mslc_pkg::RASTER_BYTES / Cv);
	end
	assign rast_align[0] = SW'(mslc_pkg::RASTER_BYTES);

	// level dimensions
	logic [15:0] src_w, src_h, sh_w, sh_h, lw0, lh0;
	logic [DW-1:0] lw1, lh1;
	logic [12:0] src_d, sh_d, ld;
	logic [4:0]  ubw, ubh;
	logic [5:0]  ubw2;
	logic [6:0]  ubw4;
	logic        free_pick;

	assign src_w = (lv_q < LW'(2)) ? {1'b0, w_q} : pw_q;
	assign src_h = (lv_q < LW'(2)) ? {1'b0, h_q} : ph_q;
	assign src_d = (lv_q == '0) ? {1'b0, d_q} : pd_q;
	assign sh_w  = src_w >> lv_q;
	assign sh_h  = src_h >> lv_q;
	assign sh_d  = src_d >> lv_q;
	assign lw0   = (sh_w == '0) ? 16'd1 : sh_w;
	assign lh0   = (sh_h == '0) ? 16'd1 : sh_h;
	assign ld    = (sh_d == '0) ? 13'd1 : sh_d;
	assign lw1   = msaa_q ? {lw0, 1'b0} : {1'b0, lw0};
	assign lh1   = msaa_q ? {lh0, 1'b0} : {1'b0, lh0};
	assign ubw   = {utw_q, 1'b0};
	assign ubh   = {uth_q, 1'b0};
	assign ubw2  = {utw_q, 2'b0};
	assign ubw4  = {utw_q, 3'b0};
	assign free_pick = (lv_q != '0) || !msaa_q;

	// mode pick on the block-divided size (width in lw_q, height arriving as q)
	mslc_pkg::mode_t mode_c;
	logic [SW-1:0] aw_c, ah_c;

	always_comb begin
		mode_c = mslc_pkg::MODE_UIF_NOXOR;
		aw_c   = ubw4;
		ah_c   = SW'(ubh);
		if (!tiled_q) begin
			mode_c = mslc_pkg::MODE_RASTER;
			aw_c   = rast_align[cpp_q];
			ah_c   = SW'(1);
		end else if (free_pick && (lw_q <= DW'(utw_q) || q <= DW'(uth_q))) begin
			mode_c = mslc_pkg::MODE_LT;
			aw_c   = SW'(utw_q);
			ah_c   = SW'(uth_q);
		end else if (free_pick && lw_q <= DW'(ubw)) begin
			mode_c = mslc_pkg::MODE_UBL1;
			aw_c   = SW'(ubw);
		end else if (free_pick && lw_q <= DW'(ubw2)) begin
			mode_c = mslc_pkg::MODE_UBL2;
			aw_c   = SW'(ubw2);
		end
	end

	// divider operands
	always_comb begin
		dx = lh_q;
		da = SW'(1);
		unique case (state_q)
			mslc_pkg::S_DW: begin
				dx = lw1 + DW'(bw_q) - DW'(1);
				da = SW'(bw_q);
			end
			mslc_pkg::S_DH: begin
				dx = lh1 + DW'(bh_q) - DW'(1);
				da = SW'(bh_q);
			end
			mslc_pkg::S_RW: begin
				dx = lw_q + DW'(aw_c) - DW'(1);
				da = aw_c;
			end
			mslc_pkg::S_RH: begin
				dx = lh_q + DW'(ah_q) - DW'(1);
				da = ah_q;
			end
			default: begin
				dx = lh_q;
				da = SW'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= dx * recip[da];
		da_s1   <= da;
	end

	assign q       = prod_s1[mslc_pkg::DIV_K +: DW];
	assign qa_full = q * da_s1;
	assign qa      = qa_full[DW-1:0];

	// bank conflict padding
	logic [PC_W_L-1:0] boff;
	localparam int PC_W_L = mslc_pkg::PC_W;
	logic [4:0]  pad_c;
	logic [DW-1:0] hub2_c;
	logic [11:0] padrows_c;
	logic        uif_c;

	assign uif_c = (mode_q == mslc_pkg::MODE_UIF_NOXOR);
	assign boff  = q[PC_W_L-1:0];

	always_comb begin
		pad_c = '0;
		if (uif_c && boff != '0) begin
			if (boff < PC_W_L'(mslc_pkg::PG_1_5)) begin
				pad_c = (q < DW'(mslc_pkg::PC_UB_ROWS)) ? 5'd0 :
					5'(mslc_pkg::PG_1_5 - 32'(boff));
			end else if (boff > PC_W_L'(mslc_pkg::PC_MINUS_1_5)) begin
				pad_c = 5'(mslc_pkg::PC_UB_ROWS - 32'(boff));
			end
		end
	end

	assign hub2_c    = q + DW'(pad_c);
	assign padrows_c = pad_c * ah_q;

	// per-level products
	logic [38:0] slice_full;
	logic [44:0] whole_full;
	logic [9:0]  lim_rows;
	logic [31:0] whole_pg;
	logic [32:0] acc_sum;
	logic        pg_ov;

	assign slice_full = lh_q * stride_q;
	assign whole_full = slice_q * ld;
	assign lim_rows   = 10'(mslc_pkg::PC_MINUS_1_5) * 10'(ubh);
	assign pg_ov      = page_q && (whole_q > (32'hFFFFFFFF - 32'(mslc_pkg::PAGE_BYTES) + 32'd1));
	assign whole_pg   = page_q ?
		{whole_q[31:PW] + (32-PW)'(|whole_q[PW-1:0]), {PW{1'b0}}} : whole_q;
	assign acc_sum    = {1'b0, run_q} + {1'b0, whole_pg};

	assign wr_entry.offset = run_q;
	assign wr_entry.stride = 32'(stride_q);
	assign wr_entry.rows   = lh_q;
	assign wr_entry.size   = slice_q;
	assign wr_entry.mode   = mode_q;
	assign wr_entry.pad    = pad_q;
	assign wr_entry.ublk   = hub_q;

	// final sums
	logic [PW-1:0] shift_c;
	logic [32:0] tot_sh, off_sh, s_sum, fin_sum;
	logic [31:0] s_round;
	logic        s_rov;
	logic [43:0] lprod_full;

	assign shift_c    = PW'(~off0_q[PW-1:0]) + PW'(1);
	assign tot_sh     = {1'b0, run_q} + 33'(shift_c);
	assign off_sh     = {1'b0, off0_q} + 33'(shift_c);
	assign s_sum      = {1'b0, off0_q} + {1'b0, size0_q};
	assign s_round    = {s_sum[31:6] + 26'(|s_sum[5:0]), 6'b0};
	assign s_rov      = s_sum[31:0] > (32'hFFFFFFFF - 32'(mslc_pkg::ROW_ALIGN) + 32'd1);
	assign lprod_full = lstride_q * (layers_q - 12'd1);
	assign fin_sum    = {1'b0, total_q} + {1'b0, lprod_q};

	// input capture values
	logic [14:0] w_in, h_in;
	logic [11:0] d_in, l_in;
	logic [3:0]  n_in;
	logic [4:0]  n_cap;
	logic [14:0] p_w, p_h, p_d;

	assign w_in  = (base_width == '0) ? 15'd1 : base_width;
	assign h_in  = (base_height == '0) ? 15'd1 : base_height;
	assign d_in  = (base_depth == '0) ? 12'd1 : base_depth;
	assign l_in  = (layer_count == '0) ? 12'd1 : layer_count;
	assign n_in  = (level_count == '0) ? 4'd1 : level_count;
	assign n_cap = (5'(n_in) > 5'(mslc_pkg::MAX_LEVELS)) ? 5'(mslc_pkg::MAX_LEVELS) : 5'(n_in);
	assign p_w   = mslc_pkg::pow2_up((w_in >> 1) == '0 ? 14'd1 : 14'(w_in >> 1));
	assign p_h   = mslc_pkg::pow2_up((h_in >> 1) == '0 ? 14'd1 : 14'(h_in >> 1));
	assign p_d   = mslc_pkg::pow2_up((d_in >> 1) == '0 ? 14'd1 : 14'(d_in >> 1));

	logic acc_in, ld_ok;

	assign in_stall = (state_q != mslc_pkg::S_IDLE);
	assign acc_in   = in_valid && !in_stall;
	assign ld_ok    = (state_q == mslc_pkg::S_ELD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mslc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mslc_pkg::S_IDLE: if (in_valid) state_d = mslc_pkg::S_DW;
			mslc_pkg::S_DW:   state_d = mslc_pkg::S_DH;
			mslc_pkg::S_DH:   state_d = mslc_pkg::S_RW;
			mslc_pkg::S_RW:   state_d = mslc_pkg::S_RH;
			mslc_pkg::S_RH:   state_d = mslc_pkg::S_PAD;
			mslc_pkg::S_PAD:  state_d = mslc_pkg::S_SL;
			mslc_pkg::S_SL:   state_d = mslc_pkg::S_WH;
			mslc_pkg::S_WH:   state_d = mslc_pkg::S_ACC;
			mslc_pkg::S_ACC:  state_d = (lv_q == '0) ? mslc_pkg::S_F1 : mslc_pkg::S_DW;
			mslc_pkg::S_F1:   state_d = mslc_pkg::S_F2;
			mslc_pkg::S_F2:   state_d = mslc_pkg::S_F3;
			mslc_pkg::S_F3:   state_d = mslc_pkg::S_F4;
			mslc_pkg::S_F4:   state_d = mslc_pkg::S_ERD;
			mslc_pkg::S_ERD:  state_d = mslc_pkg::S_ELD;
			mslc_pkg::S_ELD: begin
				if (ld_ok) begin
					state_d = (emit_q == last_q) ? mslc_pkg::S_IDLE : mslc_pkg::S_ERD;
				end
			end
			default: state_d = mslc_pkg::S_IDLE;
		endcase
	end

	// level table memory
	always_ff @(posedge clk) begin
		if (state_q == mslc_pkg::S_ACC) begin
			mem[lv_q] <= wr_entry;
		end
		rd_q <= mem[emit_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mslc_pkg::S_IDLE: begin
				if (acc_in) begin
					w_q      <= w_in;
					h_q      <= h_in;
					d_q      <= d_in;
					cpp_q    <= (bytes_per_block == '0) ? 5'd1 : bytes_per_block;
					utw_q    <= (utile_width == '0) ? 4'd1 : utile_width;
					uth_q    <= (utile_height == '0) ? 4'd1 : utile_height;
					bw_q     <= (block_width == '0) ? 4'd1 : block_width;
					bh_q     <= (block_height == '0) ? 4'd1 : block_height;
					layers_q <= l_in;
					msaa_q   <= multisampled;
					tiled_q  <= (image_kind != 2'd0);
					is3d_q   <= (image_kind == 2'd2);
					pw_q     <= {p_w, 1'b0};
					ph_q     <= {p_h, 1'b0};
					pd_q     <= 13'({p_d, 1'b0});
					last_q   <= LW'(n_cap - 5'd1);
					lv_q     <= LW'(n_cap - 5'd1);
					run_q    <= '0;
				end
			end
			mslc_pkg::S_DH: begin
				lw_q <= q;
			end
			mslc_pkg::S_RW: begin
				lh_q   <= q;
				mode_q <= mode_c;
				ah_q   <= ah_c;
			end
			mslc_pkg::S_RH: begin
				lw_q <= qa;
			end
			mslc_pkg::S_PAD: begin
				lh_q     <= qa + DW'(padrows_c);
				pad_q    <= pad_c;
				hub_q    <= hub2_c[15:0];
				stride_q <= lw_q * cpp_q;
				if (uif_c) begin
					mode_q <= (hub2_c[PC_W_L-1:0] == '0) ?
						mslc_pkg::MODE_UIF_XOR : mslc_pkg::MODE_UIF_NOXOR;
				end
			end
			mslc_pkg::S_SL: begin
				slice_q <= slice_full[31:0];
				page_q  <= (lv_q == LW'(1)) && (lw_q > DW'(ubw4)) && (lh_q > DW'(lim_rows));
			end
			mslc_pkg::S_WH: begin
				whole_q <= whole_full[31:0];
			end
			mslc_pkg::S_ACC: begin
				run_q <= acc_sum[31:0];
				if (lv_q == '0) begin
					off0_q  <= run_q;
					size0_q <= slice_q;
				end else begin
					lv_q <= lv_q - LW'(1);
				end
			end
			mslc_pkg::S_F1: begin
				shift_q <= shift_c;
				total_q <= tot_sh[31:0];
				off0_q  <= off_sh[31:0];
			end
			mslc_pkg::S_F2: begin
				lstride_q <= is3d_q ? size0_q : s_round;
			end
			mslc_pkg::S_F3: begin
				lprod_q <= lprod_full[31:0];
			end
			mslc_pkg::S_F4: begin
				if (!is3d_q) begin
					total_q <= fin_sum[31:0];
				end
				emit_q <= '0;
			end
			mslc_pkg::S_ELD: begin
				if (ld_ok && emit_q != last_q) begin
					emit_q <= emit_q + LW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// overflow flag of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			case (state_q)
				mslc_pkg::S_IDLE: if (acc_in) ov_q <= 1'b0;
				mslc_pkg::S_SL:   if (slice_full[38:32] != '0) ov_q <= 1'b1;
				mslc_pkg::S_WH:   if (whole_full[44:32] != '0) ov_q <= 1'b1;
				mslc_pkg::S_ACC:  if (pg_ov || acc_sum[32]) ov_q <= 1'b1;
				mslc_pkg::S_F1:   if (tot_sh[32] || off_sh[32]) ov_q <= 1'b1;
				mslc_pkg::S_F2:   if (!is3d_q && (s_sum[32] || s_rov)) ov_q <= 1'b1;
				mslc_pkg::S_F3:   if (!is3d_q && lprod_full[43:32] != '0) ov_q <= 1'b1;
				mslc_pkg::S_F4:   if (!is3d_q && fin_sum[32]) ov_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// output beat register
	logic rd_uif, rd_last;

	assign rd_uif  = (rd_q.mode == mslc_pkg::MODE_UIF_NOXOR) ||
		(rd_q.mode == mslc_pkg::MODE_UIF_XOR);
	assign rd_last = (emit_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ok) begin
			idx_q       <= 4'(emit_q);
			mode_o_q    <= rd_q.mode;
			off_o_q     <= rd_q.offset + 32'(shift_q);
			stride_o_q  <= rd_q.stride;
			rows_o_q    <= rd_q.rows;
			pad_o_q     <= rd_uif ? rd_q.pad : 5'd0;
			ublk_o_q    <= rd_uif ? rd_q.ublk : 16'd0;
			size_o_q    <= rd_q.size;
			total_o_q   <= rd_last ? total_q : 32'd0;
			lstride_o_q <= rd_last ? lstride_q : 32'd0;
			ov_o_q      <= ov_q;
			last_o_q    <= rd_last;
		end
	end

	assign out_valid          = out_valid_q;
	assign level_index        = idx_q;
	assign tiling_mode        = mode_o_q;
	assign slice_offset       = off_o_q;
	assign row_stride         = stride_o_q;
	assign padded_rows        = rows_o_q;
	assign uif_pad            = pad_o_q;
	assign rows_in_uif_blocks = ublk_o_q;
	assign slice_bytes        = size_o_q;
	assign total_bytes        = total_o_q;
	assign layer_stride       = lstride_o_q;
	assign overflow           = ov_o_q;
	assign last               = last_o_q;

endmodule
